### rtl/core/wlbt_pkg.sv
// ----------------------------------------------------------------------------
// wlbt_pkg
// types, codes and the control store of the wear leveling block table
// ----------------------------------------------------------------------------
package wlbt_pkg;

    localparam int IDX_PORT_W = 8;
    localparam int WEAR_W     = 32;
    localparam int FOUND_W    = 8;
    localparam int FTOT_W     = 9;
    // wide enough for any index or count at the largest table size
    localparam int EXT_W      = 14;
    localparam int UPC_W      = 4;

    localparam logic [WEAR_W-1:0] WEAR_MAX = '1;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_SET_STATE,
        OP_SET_WEAR,
        OP_READ,
        OP_FIND_MIN,
        OP_FIND_MAX,
        OP_COUNT_FREE
    } op_t;

    typedef enum logic [1:0] {
        BS_FREE,
        BS_USED,
        BS_DIRTY,
        BS_BAD
    } blk_state_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_NONE
    } status_t;

    typedef logic [UPC_W-1:0] upc_t;

    // control store addresses
    localparam upc_t U_CLEAR     = 4'd0;
    localparam upc_t U_IDLE      = 4'd1;
    localparam upc_t U_SCAN_INIT = 4'd2;
    localparam upc_t U_SCAN      = 4'd3;
    localparam upc_t U_DRAIN     = 4'd4;
    localparam upc_t U_ALLOC_WR  = 4'd5;
    localparam upc_t U_EMIT      = 4'd6;
    localparam upc_t U_RETURN    = 4'd7;
    localparam upc_t U_ACCESS    = 4'd8;
    localparam upc_t U_CAPTURE   = 4'd9;

    // jump condition: taken goes to target, not taken goes to the next step
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NOT_LAST,
        JC_DISPATCH,
        JC_OUT_BUSY,
        JC_NOT_READ
    } jc_t;

    typedef struct packed {
        logic clr_we;
        logic accept;
        logic scan_init;
        logic rd_issue;
        logic addr_inc;
        logic idx_access;
        logic capture;
        logic alloc_wr;
        logic emit;
        jc_t  jc;
        upc_t target;
    } ctrl_t;

    typedef struct packed {
        logic req_valid;
        op_t  op_in;
        logic last;
        logic out_busy;
        logic not_read;
    } flags_t;

    typedef struct packed {
        status_t             status;
        logic [FOUND_W-1:0]  found;
        logic [1:0]          est;
        logic [WEAR_W-1:0]   ewear;
        logic [FTOT_W-1:0]   ftot;
    } result_t;

    function automatic ctrl_t ucode_rom(input upc_t upc);
        ctrl_t w;
        w        = '0;
        w.jc     = JC_ALWAYS;
        w.target = U_IDLE;
        case (upc)
            U_CLEAR:
            begin
                w.clr_we   = 1'b1;
                w.addr_inc = 1'b1;
                w.jc       = JC_NOT_LAST;
                w.target   = U_CLEAR;
            end
            U_IDLE:
            begin
                w.accept = 1'b1;
                w.jc     = JC_DISPATCH;
                w.target = U_IDLE;
            end
            U_SCAN_INIT:
            begin
                w.scan_init = 1'b1;
                w.jc        = JC_NEXT;
            end
            U_SCAN:
            begin
                w.rd_issue = 1'b1;
                w.addr_inc = 1'b1;
                w.jc       = JC_NOT_LAST;
                w.target   = U_SCAN;
            end
            U_DRAIN:
            begin
                w.jc = JC_NEXT;
            end
            U_ALLOC_WR:
            begin
                w.alloc_wr = 1'b1;
                w.jc       = JC_NEXT;
            end
            U_EMIT:
            begin
                w.emit   = 1'b1;
                w.jc     = JC_OUT_BUSY;
                w.target = U_EMIT;
            end
            U_RETURN:
            begin
                w.jc     = JC_ALWAYS;
                w.target = U_IDLE;
            end
            U_ACCESS:
            begin
                w.idx_access = 1'b1;
                w.jc         = JC_NOT_READ;
                w.target     = U_EMIT;
            end
            U_CAPTURE:
            begin
                w.capture = 1'b1;
                w.jc      = JC_ALWAYS;
                w.target  = U_EMIT;
            end
            default:
            begin
                w.jc     = JC_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/core/wlbt_ram.sv
// ----------------------------------------------------------------------------
// wlbt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module wlbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/wlbt_seq.sv
// ----------------------------------------------------------------------------
// wlbt_seq
// microcode sequencer: step counter, control store and jump logic
// ----------------------------------------------------------------------------
module wlbt_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  wlbt_pkg::flags_t flags,
    output wlbt_pkg::ctrl_t  ctrl
);

    import wlbt_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;
    logic is_scan_op;

    assign ctrl    = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + upc_t'(1);

    always_comb
    begin
        is_scan_op = flags.op_in inside {OP_ALLOC, OP_FIND_MIN, OP_FIND_MAX, OP_COUNT_FREE};
    end

    always_comb
    begin
        case (ctrl.jc)
            JC_NEXT:     upc_next = upc_inc;
            JC_ALWAYS:   upc_next = ctrl.target;
            JC_NOT_LAST: upc_next = flags.last ? upc_inc : ctrl.target;
            JC_DISPATCH:
            begin
                if (flags.req_valid)
                begin
                    upc_next = is_scan_op ? U_SCAN_INIT : U_ACCESS;
                end
                else
                begin
                    upc_next = ctrl.target;
                end
            end
            JC_OUT_BUSY: upc_next = flags.out_busy ? ctrl.target : upc_inc;
            JC_NOT_READ: upc_next = flags.not_read ? ctrl.target : upc_inc;
            default:     upc_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

### rtl/core/wlbt_dp.sv
// ----------------------------------------------------------------------------
// wlbt_dp
// datapath: block tables, scan address, compare unit and result assembly
// ----------------------------------------------------------------------------
module wlbt_dp #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wlbt_pkg::ctrl_t                     ctrl,
    input  logic                                req_valid,
    input  logic [2:0]                          opcode,
    input  logic [wlbt_pkg::IDX_PORT_W-1:0]     block_index,
    input  logic [1:0]                          new_state,
    input  logic [wlbt_pkg::WEAR_W-1:0]         wear_value,
    output logic                                last,
    output logic                                not_read,
    output wlbt_pkg::result_t                   result
);

    import wlbt_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    op_t                   op_reg;
    logic [IDX_PORT_W-1:0] idx_reg;
    logic [1:0]            nst_reg;
    logic [WEAR_W-1:0]     wv_reg;

    logic [IDX_W-1:0]      addr_reg;
    logic                  rd_v_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [WEAR_W-1:0]     best_reg;
    logic [IDX_W-1:0]      pick_reg;
    logic                  hit_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [1:0]            cap_state_reg;
    logic [WEAR_W-1:0]     cap_wear_reg;

    logic [EXT_W-1:0]      idx_ext;
    logic [EXT_W-1:0]      pick_ext;
    logic [EXT_W-1:0]      cnt_ext;
    logic                  idx_ok;
    logic [IDX_W-1:0]      idx_addr;

    logic                  st_we;
    logic [IDX_W-1:0]      st_waddr;
    logic [1:0]            st_wdata;
    logic                  wr_we;
    logic [IDX_W-1:0]      wr_waddr;
    logic [WEAR_W-1:0]     wr_wdata;
    logic [IDX_W-1:0]      raddr;
    logic [1:0]            st_rdata;
    logic [WEAR_W-1:0]     wr_rdata;

    logic                  qualify;

    assign idx_ext  = {{(EXT_W-IDX_PORT_W){1'b0}}, idx_reg};
    assign idx_ok   = idx_ext < EXT_W'(NUM_BLOCKS);
    assign idx_addr = idx_ext[IDX_W-1:0];
    assign pick_ext = {{(EXT_W-IDX_W){1'b0}}, pick_reg};
    assign cnt_ext  = {{(EXT_W-CNT_W){1'b0}}, cnt_reg};

    assign last     = addr_reg == LAST_IDX;
    assign not_read = !((op_reg == OP_READ) && idx_ok);
    assign raddr    = ctrl.rd_issue ? addr_reg : idx_addr;

    // write port steering
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = idx_addr;
        st_wdata = BS_FREE;
        wr_we    = 1'b0;
        wr_waddr = idx_addr;
        wr_wdata = wv_reg;
        if (ctrl.clr_we)
        begin
            st_we    = 1'b1;
            st_waddr = addr_reg;
            wr_we    = 1'b1;
            wr_waddr = addr_reg;
            wr_wdata = '0;
        end
        else if (ctrl.idx_access && idx_ok)
        begin
            case (op_reg)
                OP_FREE:      st_we = 1'b1;
                OP_SET_STATE:
                begin
                    st_we    = 1'b1;
                    st_wdata = nst_reg;
                end
                OP_SET_WEAR:  wr_we = 1'b1;
                default:      st_we = 1'b0;
            endcase
        end
        else if (ctrl.alloc_wr && (op_reg == OP_ALLOC) && hit_reg)
        begin
            st_we    = 1'b1;
            st_waddr = pick_reg;
            st_wdata = BS_DIRTY;
        end
    end

    wlbt_ram #(
        .WIDTH (2),
        .DEPTH (NUM_BLOCKS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    wlbt_ram #(
        .WIDTH (WEAR_W),
        .DEPTH (NUM_BLOCKS)
    ) u_wear_ram (
        .clk   (clk),
        .we    (wr_we),
        .waddr (wr_waddr),
        .wdata (wr_wdata),
        .raddr (raddr),
        .rdata (wr_rdata)
    );

    // candidate test for the entry coming out of the tables
    always_comb
    begin
        case (op_reg)
            OP_ALLOC:    qualify = (st_rdata == BS_FREE) && (wr_rdata < best_reg);
            OP_FIND_MIN: qualify = ((st_rdata == BS_FREE) || (st_rdata == BS_USED))
                                   && (wr_rdata < best_reg);
            OP_FIND_MAX: qualify = (st_rdata == BS_USED) && (wr_rdata > best_reg);
            default:     qualify = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            rd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= ctrl.rd_issue;
            if (ctrl.scan_init)
            begin
                addr_reg <= '0;
            end
            else if (ctrl.addr_inc)
            begin
                addr_reg <= last ? '0 : addr_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && req_valid)
        begin
            op_reg  <= op_t'(opcode);
            idx_reg <= block_index;
            nst_reg <= new_state;
            wv_reg  <= wear_value;
        end
        rd_addr_reg <= addr_reg;
        if (ctrl.scan_init)
        begin
            best_reg <= (op_reg == OP_FIND_MAX) ? '0 : WEAR_MAX;
            hit_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (rd_v_reg)
        begin
            if (qualify)
            begin
                best_reg <= wr_rdata;
                pick_reg <= rd_addr_reg;
                hit_reg  <= 1'b1;
            end
            if (st_rdata == BS_FREE)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        if (ctrl.capture)
        begin
            cap_state_reg <= st_rdata;
            cap_wear_reg  <= wr_rdata;
        end
    end

    always_comb
    begin
        result = '0;
        case (op_reg)
            OP_ALLOC, OP_FIND_MIN, OP_FIND_MAX:
            begin
                result.status = hit_reg ? ST_OK : ST_NONE;
                result.found  = hit_reg ? pick_ext[FOUND_W-1:0] : '0;
            end
            OP_FREE, OP_SET_STATE, OP_SET_WEAR:
            begin
                result.status = idx_ok ? ST_OK : ST_INVALID;
            end
            OP_READ:
            begin
                if (idx_ok)
                begin
                    result.est   = cap_state_reg;
                    result.ewear = cap_wear_reg;
                end
                else
                begin
                    result.status = ST_INVALID;
                    result.est    = BS_BAD;
                end
            end
            OP_COUNT_FREE:
            begin
                result.ftot = cnt_ext[FTOT_W-1:0];
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

### rtl/core/wear_leveling_block_table.sv
// ----------------------------------------------------------------------------
// wear_leveling_block_table
// per-block state and wear table with allocate, search, count and per-entry access operations
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_BLOCKS entries, writing
// every entry to free with zero wear; req_ready stays low until it ends.
// Each request then yields exactly one response. Allocate, find min, find
// max and count free walk the whole table one entry per cycle through the
// registered read port of the table memories and occupy the block for a
// full pass. Free, set state and set wear run access, emit and return
// steps; read entry of a valid index adds a capture step after access.
// Control comes from a small microcode store stepped by the sequencer; the
// response is held in an output register, so a new request is taken while
// the previous response still waits for rsp_ready, and the sequencer only
// holds in its emit step when that register is still occupied.
// ----------------------------------------------------------------------------
module wear_leveling_block_table #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [2:0]                       opcode,
    input  logic [wlbt_pkg::IDX_PORT_W-1:0]  block_index,
    input  logic [1:0]                       new_state,
    input  logic [wlbt_pkg::WEAR_W-1:0]      wear_value,
    // response channel
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [1:0]                       status,
    output logic [wlbt_pkg::FOUND_W-1:0]     found_index,
    output logic [1:0]                       entry_state_out,
    output logic [wlbt_pkg::WEAR_W-1:0]      entry_wear_out,
    output logic [wlbt_pkg::FTOT_W-1:0]      free_total
);

    import wlbt_pkg::*;

    ctrl_t   ctrl;
    flags_t  flags;
    result_t result;
    logic    dp_last;
    logic    dp_not_read;

    // response register
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    logic    out_busy;
    logic    emit_fire;

    // a held response that is not being taken blocks the emit step
    assign out_busy  = out_valid_reg && !rsp_ready;
    assign emit_fire = ctrl.emit && !out_busy;

    // requests are only taken in the idle step of the microcode
    assign req_ready = ctrl.accept;

    always_comb
    begin
        flags.req_valid = req_valid;
        flags.op_in     = op_t'(opcode);
        flags.last      = dp_last;
        flags.out_busy  = out_busy;
        flags.not_read  = dp_not_read;
    end

    wlbt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    wlbt_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .req_valid   (req_valid),
        .opcode      (opcode),
        .block_index (block_index),
        .new_state   (new_state),
        .wear_value  (wear_value),
        .last        (dp_last),
        .not_read    (dp_not_read),
        .result      (result)
    );

    // response valid: set by the emit step, cleared when the transfer completes
    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg <= result;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign found_index     = out_reg.found;
    assign entry_state_out = out_reg.est;
    assign entry_wear_out  = out_reg.ewear;
    assign free_total      = out_reg.ftot;

    // every accepted request keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready
    ) else $error("request taken in back to back cycles");

    // index errors carry no search result and no count
    a_invalid_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_INVALID)) |-> ((found_index == '0) && (free_total == '0))
    ) else $error("index error response carries search or count data");

    // a fresh response is loaded only into an empty or draining output register
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_reg))
    ) else $error("pending response overwritten");

    // no block found never reports a found index or entry wear
    a_none_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_NONE)) |-> ((found_index == '0) && (entry_wear_out == '0))
    ) else $error("no block found response carries data");

endmodule
